>>> rtl/core/rcaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcaf_pkg: shared types and constants of the arming and failsafe core
// Item layouts, sequencer states, register indexes and stick thresholds.
// ----------------------------------------------------------------------------
package rcaf_pkg;

  localparam int unsigned ChW     = 11;
  localparam int unsigned InBits  = 57;
  localparam int unsigned OutBits = 68;

  typedef logic [ChW-1:0] chan_t;

  typedef enum logic [2:0] {
    ST_WAIT_LOW  = 3'd0,
    ST_WAIT_HIGH = 3'd1,
    ST_WAIT_LOW2 = 3'd2,
    ST_ARMING    = 3'd3,
    ST_ARMED     = 3'd4,
    ST_EXIT      = 3'd5
  } seq_state_e;

  typedef enum logic [2:0] {
    CFG_LOSS_TICKS  = 3'd0,
    CFG_RAMP_PERIOD = 3'd1,
    CFG_RAMP_STEP   = 3'd2,
    CFG_ARM_HOLD    = 3'd3,
    CFG_ARM_TIMEOUT = 3'd4,
    CFG_IDLE_DISARM = 3'd5,
    CFG_STALE_AGE   = 3'd6
  } cfg_idx_e;

  localparam chan_t ThrArmLow    = 11'd1200;
  localparam chan_t ThrArmHigh   = 11'd1850;
  localparam chan_t ThrArmLow2   = 11'd1150;
  localparam chan_t YawCorner    = 11'd1150;
  localparam chan_t ThrIdle      = 11'd1020;
  localparam chan_t ThrRampMin   = 11'd1030;
  localparam chan_t ThrCorner    = 11'd1050;
  localparam chan_t ThrMax       = 11'd2000;
  localparam chan_t ThrMin       = 11'd1000;
  localparam chan_t YawAutoArm   = 11'd2000;
  localparam chan_t RollNeutral  = 11'd1499;
  localparam chan_t PitchNeutral = 11'd1500;
  localparam chan_t YawNeutral   = 11'd1501;

  localparam logic [11:0] LossSat = 12'hFFF;

  // Packed with the first field in the highest bits.
  typedef struct packed {
    logic       external_lock;
    logic       motor_test_on;
    logic       test_cancel_switch;
    logic       auto_arm_switch;
    chan_t      yaw_in;
    chan_t      pitch_in;
    chan_t      roll_in;
    chan_t      throttle_in;
    logic       wifi_fresh;
    logic [7:0] link_age;
  } in_item_t;

  typedef struct packed {
    logic        warn_blink;
    logic        arm_event;
    logic        radio_reset;
    logic [15:0] loss_events;
    chan_t       yaw_out;
    chan_t       pitch_out;
    chan_t       roll_out;
    chan_t       throttle_out;
    logic        failsafe_on;
    logic [2:0]  arm_step;
    logic        armed;
  } out_item_t;

endpackage
`default_nettype wire

>>> rtl/core/rc_arming_failsafe_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc_arming_failsafe_core: arming sequencer and radio link failsafe
// Holds the stick channels, runs the arming sequence and the link-loss
// descent, one control tick per item.
// ----------------------------------------------------------------------------
// Each input item is one control tick. It is taken into an input register,
// the whole tick update runs combinationally from there into the result
// register, so one item is accepted every clock unless the output stalls,
// and its result is offered from the result register. The rate is set by
// the single state update per tick. Configuration registers may only be
// written while no item is in flight; register indexes above six are ignored.
module rc_arming_failsafe_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [11:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // link_age, wifi_fresh, throttle_in, roll_in, pitch_in, yaw_in,
  // auto_arm_switch, test_cancel_switch, motor_test_on, external_lock
  input  wire logic [63:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // armed, arm_step, failsafe_on, throttle_out, roll_out, pitch_out, yaw_out,
  // loss_events, radio_reset, arm_event, warn_blink
  output logic [71:0]      m_axis_tdata
);

  logic [11:0] loss_ticks_q, idle_disarm_q;
  logic [9:0]  ramp_period_q, arm_timeout_q;
  logic [7:0]  ramp_step_q, arm_hold_q, stale_age_q;

  rcaf_pkg::seq_state_e seq_q, seq_d, prev_q, prev_d;
  logic                 unlocked_q, unlocked_d;
  logic [7:0]           hold_q, hold_d;
  logic [9:0]           timeout_q, timeout_d;
  logic [11:0]          idle_q, idle_d;
  logic [11:0]          loss_q, loss_d;
  logic [9:0]           ramp_q, ramp_d;
  rcaf_pkg::chan_t      thr_q, thr_d, roll_q, roll_d, pitch_q, pitch_d, yaw_q, yaw_d;
  logic [15:0]          total_q, total_d;

  rcaf_pkg::in_item_t  in_q;
  logic                in_valid_q;
  rcaf_pkg::out_item_t out_q, out_d;
  logic                out_valid_q;
  logic                move;

  assign move          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || move;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loss_ticks_q  <= 12'd500;
      ramp_period_q <= 10'd100;
      ramp_step_q   <= 8'd20;
      arm_hold_q    <= 8'd5;
      arm_timeout_q <= 10'd310;
      idle_disarm_q <= 12'd700;
      stale_age_q   <= 8'd10;
    end else if (cfg_we_i) begin
      unique case (rcaf_pkg::cfg_idx_e'(cfg_addr_i))
        rcaf_pkg::CFG_LOSS_TICKS:  loss_ticks_q  <= cfg_wdata_i;
        rcaf_pkg::CFG_RAMP_PERIOD: ramp_period_q <= cfg_wdata_i[9:0];
        rcaf_pkg::CFG_RAMP_STEP:   ramp_step_q   <= cfg_wdata_i[7:0];
        rcaf_pkg::CFG_ARM_HOLD:    arm_hold_q    <= cfg_wdata_i[7:0];
        rcaf_pkg::CFG_ARM_TIMEOUT: arm_timeout_q <= cfg_wdata_i[9:0];
        rcaf_pkg::CFG_IDLE_DISARM: idle_disarm_q <= cfg_wdata_i;
        rcaf_pkg::CFG_STALE_AGE:   stale_age_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      out_valid_q <= move || (out_valid_q && !m_axis_tready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= rcaf_pkg::in_item_t'(s_axis_tdata[rcaf_pkg::InBits-1:0]);
    end
    if (move) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q      <= rcaf_pkg::ST_WAIT_LOW;
      prev_q     <= rcaf_pkg::ST_WAIT_LOW;
      unlocked_q <= 1'b0;
      hold_q     <= '0;
      timeout_q  <= '0;
      idle_q     <= '0;
      loss_q     <= '0;
      ramp_q     <= '0;
      thr_q      <= '0;
      roll_q     <= '0;
      pitch_q    <= '0;
      yaw_q      <= '0;
      total_q    <= '0;
    end else if (move) begin
      seq_q      <= seq_d;
      prev_q     <= prev_d;
      unlocked_q <= unlocked_d;
      hold_q     <= hold_d;
      timeout_q  <= timeout_d;
      idle_q     <= idle_d;
      loss_q     <= loss_d;
      ramp_q     <= ramp_d;
      thr_q      <= thr_d;
      roll_q     <= roll_d;
      pitch_q    <= pitch_d;
      yaw_q      <= yaw_d;
      total_q    <= total_d;
    end
  end

  always_comb begin
    logic            fresh;
    logic            fs_on;
    logic            radio_rst;
    logic            arm_ev;
    logic            blink;
    rcaf_pkg::chan_t thr;

    fresh      = (in_q.link_age == 8'd1) || in_q.wifi_fresh;
    fs_on      = 1'b0;
    radio_rst  = 1'b0;
    arm_ev     = 1'b0;
    blink      = 1'b0;
    thr        = '0;
    seq_d      = seq_q;
    prev_d     = prev_q;
    unlocked_d = unlocked_q && !in_q.external_lock;
    hold_d     = hold_q;
    timeout_d  = timeout_q;
    idle_d     = idle_q;
    loss_d     = loss_q;
    ramp_d     = ramp_q;
    total_d    = total_q;
    thr_d      = fresh ? in_q.throttle_in : thr_q;
    roll_d     = fresh ? in_q.roll_in     : roll_q;
    pitch_d    = fresh ? in_q.pitch_in    : pitch_q;
    yaw_d      = fresh ? in_q.yaw_in      : yaw_q;

    // A stale link restarts a sequence that has not armed yet.
    if ((in_q.link_age > stale_age_q) && !unlocked_d) begin
      seq_d = rcaf_pkg::ST_EXIT;
      if (prev_q != rcaf_pkg::ST_EXIT) begin
        blink = 1'b1;
      end
    end
    prev_d = seq_d;

    if (in_q.link_age == 8'd1) begin
      if ((thr_d < rcaf_pkg::ThrCorner) && (yaw_d < rcaf_pkg::YawCorner) && unlocked_d) begin
        seq_d = rcaf_pkg::ST_EXIT;
      end
      if (in_q.auto_arm_switch && (thr_d == rcaf_pkg::ThrMin) &&
          (yaw_d == rcaf_pkg::YawAutoArm)) begin
        seq_d = rcaf_pkg::ST_ARMING;
      end
      unique case (seq_d)
        rcaf_pkg::ST_WAIT_LOW: begin
          if (thr_d < rcaf_pkg::ThrArmLow) begin
            seq_d = rcaf_pkg::ST_WAIT_HIGH;
          end
        end
        rcaf_pkg::ST_WAIT_HIGH: begin
          if (thr_d > rcaf_pkg::ThrArmHigh) begin
            hold_d = hold_q + 8'd1;
            if (hold_d > arm_hold_q) begin
              hold_d = '0;
              seq_d  = rcaf_pkg::ST_WAIT_LOW2;
            end
          end
        end
        rcaf_pkg::ST_WAIT_LOW2: begin
          if (thr_d < rcaf_pkg::ThrArmLow2) begin
            if (in_q.test_cancel_switch && in_q.motor_test_on) begin
              seq_d = rcaf_pkg::ST_EXIT;
            end else begin
              seq_d = rcaf_pkg::ST_ARMING;
            end
          end else begin
            timeout_d = timeout_q + 10'd1;
            if (timeout_d > arm_timeout_q) begin
              timeout_d = '0;
              seq_d     = rcaf_pkg::ST_EXIT;
              blink     = 1'b1;
            end
          end
        end
        rcaf_pkg::ST_ARMING: begin
          unlocked_d = 1'b1;
          seq_d      = rcaf_pkg::ST_ARMED;
          arm_ev     = 1'b1;
        end
        rcaf_pkg::ST_ARMED: begin
          if (thr_d < rcaf_pkg::ThrIdle) begin
            idle_d = idle_q + 12'd1;
            if (idle_q > idle_disarm_q) begin
              seq_d = rcaf_pkg::ST_EXIT;
            end
          end else begin
            idle_d = '0;
          end
          if (!unlocked_d) begin
            seq_d = rcaf_pkg::ST_EXIT;
          end
        end
        rcaf_pkg::ST_EXIT: begin
          prev_d     = rcaf_pkg::ST_EXIT;
          idle_d     = '0;
          unlocked_d = 1'b0;
          seq_d      = rcaf_pkg::ST_WAIT_LOW;
        end
        default: begin
          seq_d = rcaf_pkg::ST_EXIT;
        end
      endcase
    end

    if (fresh) begin
      loss_d = '0;
    end else begin
      if (loss_q < rcaf_pkg::LossSat) begin
        loss_d = loss_q + 12'd1;
      end
      if (loss_d > loss_ticks_q) begin
        fs_on   = 1'b1;
        total_d = total_q + 16'd1;
        roll_d  = rcaf_pkg::RollNeutral;
        pitch_d = rcaf_pkg::PitchNeutral;
        yaw_d   = rcaf_pkg::YawNeutral;
        thr     = thr_d;
        if ((thr < rcaf_pkg::ThrRampMin) || !unlocked_d) begin
          loss_d     = '0;
          thr        = rcaf_pkg::ThrMin;
          unlocked_d = 1'b0;
          radio_rst  = 1'b1;
        end else begin
          loss_d = loss_ticks_q;
          ramp_d = ramp_q + 10'd1;
          if (ramp_q > ramp_period_q) begin
            ramp_d = '0;
            thr    = thr - {3'b000, ramp_step_q};
          end
        end
        if (thr < rcaf_pkg::ThrMin) begin
          thr = rcaf_pkg::ThrMin;
        end
        if (thr > rcaf_pkg::ThrMax) begin
          thr = rcaf_pkg::ThrMax;
        end
        thr_d = thr;
      end
    end

    out_d.armed        = unlocked_d;
    out_d.arm_step     = seq_d;
    out_d.failsafe_on  = fs_on;
    out_d.throttle_out = thr_d;
    out_d.roll_out     = roll_d;
    out_d.pitch_out    = pitch_d;
    out_d.yaw_out      = yaw_d;
    out_d.loss_events  = total_d;
    out_d.radio_reset  = radio_rst;
    out_d.arm_event    = arm_ev;
    out_d.warn_blink   = blink;
  end

endmodule
`default_nettype wire

>>> bench/tb_rc_arming_failsafe_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc_arming_failsafe_core: self-checking bench for the arming and failsafe core
// Streams control ticks through the core under several register settings and
// idle patterns. Arming sequences, flights and link losses are built with
// random content. Every result item is compared with a tick-by-tick
// prediction of the arming sequencer and the failsafe descent.
// ----------------------------------------------------------------------------
module tb_rc_arming_failsafe_core;
  import rcaf_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned PhaseTicks = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [11:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  rc_arming_failsafe_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Register copies used by the tick predictor and the stimulus.
  logic [11:0] lim_loss        = 12'd500;
  logic [9:0]  lim_ramp_period = 10'd100;
  logic [7:0]  lim_ramp_step   = 8'd20;
  logic [7:0]  lim_arm_hold    = 8'd5;
  logic [9:0]  lim_arm_timeout = 10'd310;
  logic [11:0] lim_idle        = 12'd700;
  logic [7:0]  lim_stale       = 8'd10;

  seq_state_e  seq_q      = ST_WAIT_LOW;
  seq_state_e  seq_prev_q = ST_WAIT_LOW;
  logic        armed_q    = 1'b0;
  logic [7:0]  hold_q     = '0;
  logic [9:0]  tmo_q      = '0;
  logic [11:0] idle_q     = '0;
  logic [11:0] loss_q     = '0;
  logic [9:0]  ramp_q     = '0;
  chan_t       thr_q = '0, roll_q = '0, pitch_q = '0, yaw_q = '0;
  logic [15:0] loss_total_q = '0;

  in_item_t    tick_q[$];
  out_item_t   expected_q[$];
  in_item_t    tick_on_bus;
  out_item_t   got, want;
  int unsigned n_pushed = 0, n_accepted = 0, n_fail = 0;
  int unsigned send_idle_pct = 0, recv_stall_pct = 0;
  int unsigned hold_asks = 0, hold_served = 0, hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned phase_items;

  function automatic out_item_t advance_tick(in_item_t t);
    out_item_t   r;
    logic        fresh;
    logic [11:0] idle_old;
    logic [9:0]  ramp_old;
    int          thr_calc;
    r = '0;
    fresh = (t.link_age == 8'd1) || t.wifi_fresh;
    if (t.external_lock) armed_q = 1'b0;
    if (fresh) begin
      thr_q   = t.throttle_in;
      roll_q  = t.roll_in;
      pitch_q = t.pitch_in;
      yaw_q   = t.yaw_in;
    end

    if (t.link_age > lim_stale && !armed_q) begin
      seq_q = ST_EXIT;
      if (seq_prev_q != ST_EXIT) r.warn_blink = 1'b1;
    end
    seq_prev_q = seq_q;
    if (t.link_age == 8'd1) begin
      if (thr_q < ThrCorner && yaw_q < YawCorner && armed_q) seq_q = ST_EXIT;
      if (t.auto_arm_switch && thr_q == ThrMin && yaw_q == YawAutoArm) seq_q = ST_ARMING;
      case (seq_q)
        ST_WAIT_LOW: begin
          if (thr_q < ThrArmLow) seq_q = ST_WAIT_HIGH;
        end
        ST_WAIT_HIGH: begin
          if (thr_q > ThrArmHigh) begin
            hold_q = hold_q + 8'd1;
            if (hold_q > lim_arm_hold) begin
              hold_q = '0;
              seq_q = ST_WAIT_LOW2;
            end
          end
        end
        ST_WAIT_LOW2: begin
          if (thr_q < ThrArmLow2) begin
            if (t.test_cancel_switch && t.motor_test_on) seq_q = ST_EXIT;
            else seq_q = ST_ARMING;
          end else begin
            tmo_q = tmo_q + 10'd1;
            if (tmo_q > lim_arm_timeout) begin
              tmo_q = '0;
              seq_q = ST_EXIT;
              r.warn_blink = 1'b1;
            end
          end
        end
        ST_ARMING: begin
          armed_q = 1'b1;
          seq_q = ST_ARMED;
          r.arm_event = 1'b1;
        end
        ST_ARMED: begin
          if (thr_q < ThrIdle) begin
            idle_old = idle_q;
            idle_q = idle_q + 12'd1;
            if (idle_old > lim_idle) seq_q = ST_EXIT;
          end else begin
            idle_q = '0;
          end
          if (!armed_q) seq_q = ST_EXIT;
        end
        ST_EXIT: begin
          seq_prev_q = ST_EXIT;
          idle_q = '0;
          armed_q = 1'b0;
          seq_q = ST_WAIT_LOW;
        end
        default: begin
          seq_q = ST_EXIT;
        end
      endcase
    end

    if (fresh) begin
      loss_q = '0;
    end else begin
      if (loss_q < LossSat) loss_q = loss_q + 12'd1;
      if (loss_q > lim_loss) begin
        r.failsafe_on = 1'b1;
        loss_total_q = loss_total_q + 16'd1;
        roll_q  = RollNeutral;
        pitch_q = PitchNeutral;
        yaw_q   = YawNeutral;
        thr_calc = int'(thr_q);
        if (thr_q < ThrRampMin || !armed_q) begin
          loss_q = '0;
          thr_calc = int'(ThrMin);
          armed_q = 1'b0;
          r.radio_reset = 1'b1;
        end else begin
          ramp_old = ramp_q;
          loss_q = lim_loss;
          ramp_q = ramp_q + 10'd1;
          if (ramp_old > lim_ramp_period) begin
            ramp_q = '0;
            thr_calc = thr_calc - int'(lim_ramp_step);
          end
        end
        if (thr_calc < int'(ThrMin)) thr_calc = int'(ThrMin);
        if (thr_calc > int'(ThrMax)) thr_calc = int'(ThrMax);
        thr_q = chan_t'(thr_calc);
      end
    end

    r.armed        = armed_q;
    r.arm_step     = seq_q;
    r.throttle_out = thr_q;
    r.roll_out     = roll_q;
    r.pitch_out    = pitch_q;
    r.yaw_out      = yaw_q;
    r.loss_events  = loss_total_q;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(advance_tick(tick_on_bus));
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tick_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          tick_on_bus = tick_q.pop_front();
          s_axis_tdata <= {{(64 - InBits){1'b0}}, tick_on_bus};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[OutBits-1:0];
        if (expected_q.size() == 0) begin
          $error("result item arrived with no tick waiting for it");
          n_fail++;
        end else begin
          want = expected_q.pop_front();
          check_field("armed", want.armed, got.armed);
          check_field("arm_step", want.arm_step, got.arm_step);
          check_field("failsafe_on", want.failsafe_on, got.failsafe_on);
          check_field("throttle_out", want.throttle_out, got.throttle_out);
          check_field("roll_out", want.roll_out, got.roll_out);
          check_field("pitch_out", want.pitch_out, got.pitch_out);
          check_field("yaw_out", want.yaw_out, got.yaw_out);
          check_field("loss_events", want.loss_events, got.loss_events);
          check_field("radio_reset", want.radio_reset, got.radio_reset);
          check_field("arm_event", want.arm_event, got.arm_event);
          check_field("warn_blink", want.warn_blink, got.warn_blink);
        end
      end
      if (hold_served != hold_asks) begin
        hold_served = hold_asks;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic chan_t ch_in(input int unsigned lo, input int unsigned hi);
    return chan_t'($urandom_range(hi, lo));
  endfunction

  task automatic queue_tick(input logic [7:0] age, input logic wf, input chan_t thr,
                            input chan_t roll, input chan_t pitch, input chan_t yaw,
                            input logic [3:0] sw);
    in_item_t t;
    t.link_age           = age;
    t.wifi_fresh         = wf;
    t.throttle_in        = thr;
    t.roll_in            = roll;
    t.pitch_in           = pitch;
    t.yaw_in             = yaw;
    t.auto_arm_switch    = sw[0];
    t.test_cancel_switch = sw[1];
    t.motor_test_on      = sw[2];
    t.external_lock      = sw[3];
    tick_q.push_back(t);
    n_pushed++;
    phase_items++;
  endtask

  task automatic fresh_tick(input chan_t thr, input chan_t yaw, input logic [3:0] sw);
    queue_tick(8'd1, 1'($urandom_range(1, 0)), thr, ch_in(0, 2047), ch_in(0, 2047), yaw, sw);
  endtask

  task automatic noise_tick();
    queue_tick(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)), ch_in(0, 2047),
               ch_in(0, 2047), ch_in(0, 2047), ch_in(0, 2047), 4'($urandom_range(15, 0)));
  endtask

  task automatic stale_tick();
    if (lim_stale < 8'd255) begin
      queue_tick(8'($urandom_range(255, lim_stale + 1)), 1'b0, ch_in(0, 2047),
                 ch_in(0, 2047), ch_in(0, 2047), ch_in(0, 2047), 4'b0000);
    end
  endtask

  // One arming attempt, a flight and usually a link loss, with random detail.
  task automatic fly_session();
    int unsigned n;
    int unsigned k;
    logic [3:0]  sw;
    repeat ($urandom_range(3, 0)) noise_tick();
    if ($urandom_range(1, 0) == 0) stale_tick();
    repeat ($urandom_range(3, 2)) fresh_tick(ch_in(1000, 1199), ch_in(1150, 2047), 4'b0000);

    n = lim_arm_hold + $urandom_range(3, 1);
    if (n > 40) n = 40;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(19, 0) == 0) fresh_tick(ch_in(1200, 1850), ch_in(0, 2047), 4'b0000);
      else fresh_tick(ch_in(1851, 2047), ch_in(0, 2047), 4'b0000);
    end
    if ($urandom_range(9, 0) == 0) stale_tick();
    if ($urandom_range(6, 0) == 0) begin
      n = lim_arm_timeout + 2;
      if (n > 50) n = 50;
      repeat (n) fresh_tick(ch_in(1150, 1850), ch_in(0, 2047), 4'b0000);
    end
    sw = {1'b0, 3'($urandom_range(7, 0)) & 3'b110};
    fresh_tick(ch_in(1000, 1149), ch_in(1150, 2047), sw);
    if ($urandom_range(6, 0) == 0) fresh_tick(ThrMin, YawAutoArm, 4'b0001);
    fresh_tick(ch_in(1050, 2047), ch_in(1150, 2047), 4'b0000);

    repeat ($urandom_range(25, 5)) begin
      case ($urandom_range(19, 0))
        0, 1, 2, 3: begin
          n = lim_idle + 3;
          if (n > 40) n = 40;
          repeat ($urandom_range(n, 1)) fresh_tick(ch_in(1000, 1019), ch_in(1150, 2047), 4'b0000);
        end
        4, 5: fresh_tick(ch_in(0, 1049), ch_in(0, 1149), 4'b0000);
        6: fresh_tick(ch_in(0, 2047), ch_in(0, 2047), 4'b1000);
        7: fresh_tick(ThrMin, YawAutoArm, 4'b0001);
        8, 9: noise_tick();
        default: fresh_tick(ch_in(1020, 2047), ch_in(1150, 2047),
                            {1'b0, 3'($urandom_range(7, 0))});
      endcase
    end

    if ($urandom_range(9, 0) < 7) begin
      if ($urandom_range(4, 0) == 0) n = lim_loss + 1 + $urandom_range(300, 100);
      else n = lim_loss + 1 + $urandom_range(40, 0);
      if (n > 520) n = 520;
      repeat (n) begin
        queue_tick(($urandom_range(9, 0) == 0) ? 8'd0 : 8'($urandom_range(255, 2)), 1'b0,
                   ch_in(0, 2047), ch_in(0, 2047), ch_in(0, 2047), ch_in(0, 2047),
                   {1'b0, 3'($urandom_range(7, 0))});
      end
      repeat (2) fresh_tick(ch_in(0, 2047), ch_in(0, 2047), 4'b0000);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [11:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_LOSS_TICKS:  lim_loss        = val;
      CFG_RAMP_PERIOD: lim_ramp_period = val[9:0];
      CFG_RAMP_STEP:   lim_ramp_step   = val[7:0];
      CFG_ARM_HOLD:    lim_arm_hold    = val[7:0];
      CFG_ARM_TIMEOUT: lim_arm_timeout = val[9:0];
      CFG_IDLE_DISARM: lim_idle        = val;
      CFG_STALE_AGE:   lim_stale       = val[7:0];
      default: ;
    endcase
  endtask

  task automatic write_limits(input int unsigned loss, input int unsigned period,
                              input int unsigned step, input int unsigned hold,
                              input int unsigned tmo, input int unsigned idle,
                              input int unsigned stale);
    write_reg(CFG_LOSS_TICKS, 12'(loss));
    write_reg(CFG_RAMP_PERIOD, 12'(period));
    write_reg(CFG_RAMP_STEP, 12'(step));
    write_reg(CFG_ARM_HOLD, 12'(hold));
    write_reg(CFG_ARM_TIMEOUT, 12'(tmo));
    write_reg(CFG_IDLE_DISARM, 12'(idle));
    write_reg(CFG_STALE_AGE, 12'(stale));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (n_accepted != n_pushed || expected_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned ph;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      repeat (4) @(posedge clk_i);
      phase_items = 0;
      case (ph)
        0: ;
        1: write_limits(1, 1, 1, 1, 1, 1, 1);
        2: write_limits(4095, 1023, 255, 255, 1023, 4095, 255);
        default: write_limits($urandom_range(30, 1), $urandom_range(8, 1),
                              $urandom_range(255, 20), $urandom_range(10, 1),
                              $urandom_range(40, 1), $urandom_range(30, 1),
                              $urandom_range(20, 1));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      if (ph == 0) begin
        queue_tick(8'd0, 1'b0, 11'd0, 11'd0, 11'd0, 11'd0, 4'b0000);
        queue_tick(8'd255, 1'b1, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 4'b1111);
        queue_tick(8'd1, 1'b0, 11'd0, 11'd0, 11'd0, 11'd0, 4'b0000);
        queue_tick(8'd5, 1'b1, 11'd1500, 11'd2047, 11'd0, 11'd1500, 4'b0000);
        queue_tick(8'd1, 1'b0, ThrMin, 11'd1500, 11'd1500, YawAutoArm, 4'b0001);
        queue_tick(8'd1, 1'b0, 11'd1500, 11'd1500, 11'd1500, 11'd1500, 4'b0000);
        queue_tick(8'd1, 1'b0, 11'd1010, 11'd1500, 11'd1500, 11'd1600, 4'b0000);
        queue_tick(8'd1, 1'b0, ThrMin, 11'd1500, 11'd1500, 11'd1000, 4'b0000);
        queue_tick(8'd1, 1'b1, ThrMin, 11'd1500, 11'd1500, YawAutoArm, 4'b0001);
        queue_tick(8'd1, 1'b0, 11'd1500, 11'd1500, 11'd1500, 11'd1500, 4'b1000);
        queue_tick(8'd1, 1'b0, 11'd1500, 11'd1500, 11'd1500, 11'd1500, 4'b0000);
        queue_tick(8'd200, 1'b0, 11'd1500, 11'd1500, 11'd1500, 11'd1500, 4'b0000);
        queue_tick(8'd255, 1'b0, 11'd1500, 11'd1500, 11'd1500, 11'd1500, 4'b0000);
        queue_tick(8'd0, 1'b0, 11'd1500, 11'd1500, 11'd1500, 11'd1500, 4'b0110);
        queue_tick(8'd1, 1'b0, 11'd1100, 11'd1500, 11'd1500, 11'd1500, 4'b0110);
      end
      while (phase_items < PhaseTicks) fly_session();
      if (ph == 4) hold_asks++;
    end
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (n_fail == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rcaf_pkg.sv
rtl/core/rc_arming_failsafe_core.sv
bench/tb_rc_arming_failsafe_core.sv
